[hw/rtl/positional_list_insert_erase_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the positional list block
// Shared concurrent-assertion wrappers, clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_INSERT_ERASE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_ERASE_MACROS_SVH

// Same-cycle implication.
`define PLI_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define PLI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/pli_pkg.sv]
// ---------------------------------------------------------------------------
// pli_pkg
// Types and constants shared by the positional list cell row and its top.
// ---------------------------------------------------------------------------
`default_nettype none

package pli_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam int KIND_W    = 2;
    localparam int POS_W     = 6;
    localparam int VAL_W     = 32;
    localparam int CNT_OUT_W = 7;
    localparam int S_DATA_W  = 40;
    localparam int M_DATA_W  = 40;

    typedef enum logic [KIND_W-1:0] {
        KIND_INSERT = 2'd0,
        KIND_ERASE  = 2'd1,
        KIND_READ   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_HOLD   = 2'd0,
        OP_INSERT = 2'd1,
        OP_ERASE  = 2'd2
    } op_t;

    // broadcast to every cell each cycle
    typedef struct packed {
        op_t              op;
        logic [POS_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } pli_cmd_t;

endpackage

`default_nettype wire

[hw/rtl/pli_cell.sv]
// ---------------------------------------------------------------------------
// pli_cell
// One list slot: holds, takes its left or right neighbor, or loads the new
// word, as the broadcast command and its own index decide.
// ---------------------------------------------------------------------------
`default_nettype none

module pli_cell
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    parameter int INDEX    = 0
)
(
    input  wire logic             clk,
    input  wire pli_cmd_t         cmd,
    input  wire logic [VAL_W-1:0] left_word,
    input  wire logic [VAL_W-1:0] right_word,
    output logic      [VAL_W-1:0] word,
    output logic      [VAL_W-1:0] rd_word
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CMP_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam logic [CMP_W-1:0] MY_IDX = CMP_W'(INDEX);

    logic [VAL_W-1:0] word_reg;
    logic [VAL_W-1:0] word_next;
    logic [CMP_W-1:0] pos_ext;
    logic             hit;

    assign pos_ext = CMP_W'(cmd.pos);
    assign hit     = (MY_IDX == pos_ext);

    always_comb
    begin
        word_next = word_reg;
        case (cmd.op)
            OP_INSERT:
            begin
                if (hit)
                begin
                    word_next = cmd.value;
                end
                else if (MY_IDX > pos_ext)
                begin
                    word_next = left_word;
                end
            end
            OP_ERASE:
            begin
                if (MY_IDX >= pos_ext)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = hit ? word_reg : '0;

endmodule

`default_nettype wire

[hw/rtl/positional_list_insert_erase.sv]
// ---------------------------------------------------------------------------
// positional_list_insert_erase
// Ordered list of signed words with insert, erase and read at a position.
// ---------------------------------------------------------------------------
// One beat is taken per clock whenever the output register is empty or its
// beat is being taken; the result beat appears in the cycle after acceptance.
// The list lives in a row of CAPACITY cells that all update on the same edge
// (hold, take the left neighbor, take the right neighbor, or load the new
// word), so an insert or erase anywhere takes one update. Reads pick the
// addressed cell through an AND-OR combine across the row. A failed
// operation leaves the list unchanged and reports ok low.
`default_nettype none

`include "positional_list_insert_erase_macros.svh"

module positional_list_insert_erase
    import pli_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // position[5:0], value[37:6], zero pad
    input  wire logic [KIND_W-1:0]   s_tuser,  // kind[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [M_DATA_W-1:0] m_tdata,  // read_value[31:0], count[38:32], zero pad
    output logic      [0:0]          m_tuser   // ok[0]
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int OW    = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic                s_acc;
    logic [POS_W-1:0]    pos;
    logic [VAL_W-1:0]    value;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    pli_cmd_t            cmd;
    logic                ok;
    logic                rd_sel;
    logic [VAL_W-1:0]    rd_any;
    logic [VAL_W-1:0]    rd_val;
    logic [OW-1:0]       cnt_wide;

    logic                m_tvalid_reg;
    logic                m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg;
    logic [M_DATA_W-1:0] m_tdata_next;
    logic                m_ok_reg;

    logic [VAL_W-1:0]    cell_word [CAPACITY];
    logic [VAL_W-1:0]    cell_rd   [CAPACITY];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_acc    = s_tvalid && s_tready;
    assign pos      = s_tdata[POS_W-1:0];
    assign value    = s_tdata[POS_W+VAL_W-1:POS_W];
    assign pos_ext  = CMP_W'(pos);
    assign cnt_ext  = CMP_W'(count_reg);

    always_comb
    begin
        cmd.op     = OP_HOLD;
        cmd.pos    = pos;
        cmd.value  = value;
        ok         = 1'b0;
        rd_sel     = 1'b0;
        count_next = count_reg;
        case (kind_t'(s_tuser))
            KIND_INSERT:
            begin
                if (pos_ext <= cnt_ext && count_reg != CAP_CNT)
                begin
                    ok         = 1'b1;
                    cmd.op     = OP_INSERT;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            KIND_ERASE:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ok         = 1'b1;
                    cmd.op     = OP_ERASE;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            KIND_READ:
            begin
                if (pos_ext < cnt_ext)
                begin
                    ok     = 1'b1;
                    rd_sel = 1'b1;
                end
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
        if (!s_acc)
        begin
            cmd.op     = OP_HOLD;
            count_next = count_reg;
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VAL_W-1:0] left_w;
            logic [VAL_W-1:0] right_w;
            if (g == 0)
            begin : g_first
                assign left_w = cmd.value;
            end
            else
            begin : g_mid_l
                assign left_w = cell_word[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign right_w = cell_word[g];
            end
            else
            begin : g_mid_r
                assign right_w = cell_word[g+1];
            end

            pli_cell #(
                .CAPACITY (CAPACITY),
                .INDEX    (g)
            ) u_cell (
                .clk        (clk),
                .cmd        (cmd),
                .left_word  (left_w),
                .right_word (right_w),
                .word       (cell_word[g]),
                .rd_word    (cell_rd[g])
            );
        end
    endgenerate

    // at most one cell hits the position
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    assign rd_val   = rd_sel ? rd_any : '0;
    assign cnt_wide = OW'(count_next);

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (s_acc)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        m_tdata_next = {{(M_DATA_W - VAL_W - CNT_OUT_W){1'b0}},
                        cnt_wide[CNT_OUT_W-1:0], rd_val};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            m_tdata_reg <= m_tdata_next;
            m_ok_reg    <= ok;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_ok_reg;

    `PLI_ASSERT_IMP(a_count_bound, 1'b1, count_reg <= CAP_CNT,
        "count above capacity")
    `PLI_ASSERT_NEXT(a_count_idle, !s_acc, $stable(count_reg),
        "count moved without an accepted beat")
    `PLI_ASSERT_NEXT(a_insert_grows, s_acc && cmd.op == OP_INSERT,
        count_reg == $past(count_reg) + CNT_W'(1), "insert did not grow count")
    `PLI_ASSERT_IMP(a_fail_zero, m_tvalid && !m_tuser[0], m_tdata[VAL_W-1:0] == '0,
        "failed beat carries nonzero read value")

endmodule

`default_nettype wire
